// ===== src/mlf_pkg.sv =====
// shared types and helpers for the memory lcd line framer
// no dependencies; imported by every module of the framer
package mlf_pkg;

   // byte kinds on the result channel
   typedef enum logic [1:0] {
      KIND_CMD     = 2'd0,
      KIND_ADDR    = 2'd1,
      KIND_PIXEL   = 2'd2,
      KIND_TRAILER = 2'd3
   } kind_type;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned COL_W     = 6;
   localparam int unsigned ROW_W     = 8;
   localparam int unsigned CSR_IDX_W = 8;
   localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h00;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_COMMAND      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LINE_ADDRESS = 8'd1;

   // one classified item as it waits between front and back
   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] addr;
      logic              frame_start;
      logic              line_start;
      logic              line_end;
      logic              frame_last;
   } desc_type;

   // queue fill status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // one result byte
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      kind_type          kind;
      logic              frame_end;
   } result_type;

   // number of result bytes an item gives, capped at three
   function automatic logic [1:0] result_count(desc_type d);
      logic [1:0] n;
      if (d.frame_start) begin
         n = 2'd3;
      end else if (d.line_start) begin
         n = d.line_end ? 2'd3 : 2'd2;
      end else begin
         n = 2'd1 + {1'b0, d.line_end} + {1'b0, d.line_end & d.frame_last};
      end
      return n;
   endfunction

   // result byte at position idx of an item
   function automatic result_type result_at(desc_type d, logic [1:0] idx);
      result_type r;
      r.data      = TRAILER_BYTE;
      r.kind      = KIND_TRAILER;
      r.frame_end = 1'b0;
      if (d.frame_start) begin
         // command, address, pixel; trailers fall off the end
         case (idx)
            2'd0: begin
               r.data = d.cmd;
               r.kind = KIND_CMD;
            end
            2'd1: begin
               r.data = d.addr;
               r.kind = KIND_ADDR;
            end
            default: begin
               r.data = d.pixel;
               r.kind = KIND_PIXEL;
            end
         endcase
      end else if (d.line_start) begin
         // address, pixel, line trailer
         case (idx)
            2'd0: begin
               r.data = d.addr;
               r.kind = KIND_ADDR;
            end
            2'd1: begin
               r.data = d.pixel;
               r.kind = KIND_PIXEL;
            end
            default: begin
               r.data = TRAILER_BYTE;
               r.kind = KIND_TRAILER;
            end
         endcase
      end else begin
         // pixel, line trailer, frame-end trailer
         case (idx)
            2'd0: begin
               r.data = d.pixel;
               r.kind = KIND_PIXEL;
            end
            2'd1: begin
               r.data = TRAILER_BYTE;
               r.kind = KIND_TRAILER;
            end
            default: begin
               r.data      = TRAILER_BYTE;
               r.kind      = KIND_TRAILER;
               r.frame_end = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

endpackage

// ===== src/mlf_front.sv =====
// front end: accepts pixel items, tracks line and column, classifies each item
// depends on mlf_pkg
module mlf_front #(
   parameter int unsigned LINES          = 128,
   parameter int unsigned BYTES_PER_LINE = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_pixel_byte,
   input  logic [7:0]                 write_command,
   input  logic [7:0]                 first_line_address,
   input  mlf_pkg::queue_status_type  q_status,
   output logic                       push,
   output mlf_pkg::desc_type          push_desc
);
   import mlf_pkg::*;

   localparam logic [COL_W:0] COL_LIMIT = (COL_W+1)'(BYTES_PER_LINE);
   localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W+1)'(LINES);

   logic [COL_W-1:0] byte_in_line_ff, byte_in_line_in;
   logic [ROW_W-1:0] line_index_ff, line_index_in;
   logic             line_start, frame_start, line_end, frame_last;

   // position flags of the current item
   always_comb begin
      line_start  = (byte_in_line_ff == '0);
      frame_start = line_start && (line_index_ff == '0);
      line_end    = ({1'b0, byte_in_line_ff} + (COL_W+1)'(1)) >= COL_LIMIT;
      frame_last  = ({1'b0, line_index_ff} + (ROW_W+1)'(1)) >= ROW_LIMIT;
   end

   // accept whenever the queue has room
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_desc.pixel       = req_pixel_byte;
      push_desc.cmd         = write_command;
      push_desc.addr        = first_line_address + line_index_ff;
      push_desc.frame_start = frame_start;
      push_desc.line_start  = line_start;
      push_desc.line_end    = line_end;
      push_desc.frame_last  = frame_last;
   end

   // counter advance per accepted item
   always_comb begin
      byte_in_line_in = byte_in_line_ff;
      line_index_in   = line_index_ff;
      if (push) begin
         if (line_end) begin
            byte_in_line_in = '0;
            line_index_in   = frame_last ? '0 : line_index_ff + ROW_W'(1);
         end else begin
            byte_in_line_in = byte_in_line_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_in_line_ff <= '0;
         line_index_ff   <= '0;
      end else begin
         byte_in_line_ff <= byte_in_line_in;
         line_index_ff   <= line_index_in;
      end
   end

endmodule

// ===== src/mlf_queue.sv =====
// two-entry item queue between front and back
// depends on mlf_pkg
module mlf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mlf_pkg::desc_type          push_desc,
   input  logic                       pop,
   output mlf_pkg::desc_type          head_desc,
   output mlf_pkg::queue_status_type  q_status
);
   import mlf_pkg::*;

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   assign head_desc      = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== src/mlf_back.sv =====
// back end: expands each queued item into its result bytes, one per cycle
// unless rsp_stall holds the output; depends on mlf_pkg
module mlf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mlf_pkg::desc_type          head_desc,
   input  mlf_pkg::queue_status_type  q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_spi_byte,
   output logic [1:0]                 rsp_byte_kind,
   output logic                       rsp_frame_end,
   output logic                       rsp_last
);
   import mlf_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] spi_byte_ff;
   logic [1:0] byte_kind_ff;
   logic       frame_end_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load, is_last;
   logic [1:0] count;
   result_type res;

   // queue not empty and output register free or draining this cycle
   assign load    = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign count   = result_count(head_desc);
   assign res     = result_at(head_desc, idx_ff);
   assign is_last = (idx_ff == count - 2'd1);
   assign pop     = load && is_last;

   // step through the results of the head item
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         spi_byte_ff  <= res.data;
         byte_kind_ff <= res.kind;
         frame_end_ff <= res.frame_end;
         last_ff      <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_spi_byte  = spi_byte_ff;
   assign rsp_byte_kind = byte_kind_ff;
   assign rsp_frame_end = frame_end_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/memory_lcd_line_framer.sv =====
// Memory LCD multi-line write framer. Takes frame-buffer pixel bytes in raster
// order and emits the write byte stream: command at frame start, line address
// before each line, the pixel bytes, a 0x00 trailer after each line and a second
// frame-end trailer after the last line. Each item gives one to three result
// bytes (one inside a line, two or three at line edges), and the back end
// emits one result byte per cycle unless rsp_stall holds the output; a
// two-entry queue lets the front accept while the back is still emitting.
// Registers are written on csr_valid with csr_ready always high; write them only
// while the framer is idle. Depends on mlf_pkg, mlf_front, mlf_queue, mlf_back.
module memory_lcd_line_framer #(
   parameter int unsigned LINES          = 128,
   parameter int unsigned BYTES_PER_LINE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pixel_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_spi_byte,
   output logic [1:0] rsp_byte_kind,
   output logic       rsp_frame_end,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data
);
   import mlf_pkg::*;

   logic [7:0]       write_command_ff;
   logic [7:0]       first_line_address_ff;
   logic             push, pop;
   desc_type         push_desc, head_desc;
   queue_status_type q_status;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_command_ff      <= 8'h01;
         first_line_address_ff <= 8'h01;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WRITE_COMMAND) begin
            write_command_ff <= csr_data;
         end else if (csr_index == CSR_FIRST_LINE_ADDRESS) begin
            first_line_address_ff <= csr_data;
         end
      end
   end

   mlf_front #(
      .LINES          (LINES),
      .BYTES_PER_LINE (BYTES_PER_LINE)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_byte     (req_pixel_byte),
      .write_command      (write_command_ff),
      .first_line_address (first_line_address_ff),
      .q_status           (q_status),
      .push               (push),
      .push_desc          (push_desc)
   );

   mlf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_status  (q_status)
   );

   mlf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_desc     (head_desc),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_spi_byte  (rsp_spi_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_frame_end (rsp_frame_end),
      .rsp_last      (rsp_last)
   );

endmodule
